### rtl/core/pic_pkg.sv
`timescale 1ns / 1ps

package pic_pkg;

	localparam int SQ_BITS     = 34;
	localparam int SQ_HALF     = 17;
	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 6;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;

	typedef enum logic [2:0] {
		REG_AXIS_START_X = 3'd0,
		REG_AXIS_START_Y = 3'd1,
		REG_AXIS_START_Z = 3'd2,
		REG_AXIS_END_X   = 3'd3,
		REG_AXIS_END_Y   = 3'd4,
		REG_AXIS_END_Z   = 3'd5,
		REG_AXIS_LEN_SQ  = 3'd6,
		REG_RADIUS_SQ    = 3'd7
	} reg_idx_t;

endpackage

### rtl/core/pic_if.sv
`timescale 1ns / 1ps

interface pic_point_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;

	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pic_result_if;
	logic                        valid;
	logic                        ready;
	logic                        inside_res;
	logic [pic_pkg::SQ_BITS-1:0] axis_dist_sq;

	modport source (output valid, inside_res, axis_dist_sq, input ready);
	modport sink (input valid, inside_res, axis_dist_sq, output ready);
endinterface

### rtl/core/point_in_cylinder_test_top.sv
`timescale 1ns / 1ps

// Tests each point request against a capped cylinder set by the eight configuration registers
// and returns an inside flag with the squared distance to the axis, which is zero when outside.
// One request is taken every cycle unless a full queue stalls the front end; its result passes
// 41 registers: the difference, product and sum registers, one in the four-entry queue, the
// projection's partial-product and square registers, a 34-stage restoring divider yielding one
// quotient bit per stage, and the output register. A stalled result holds the whole back end.
module point_in_cylinder_test_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pic_point_if.sink                          point,
	pic_result_if.source                       result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pic_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pic_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pic_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int SQ   = pic_pkg::SQ_BITS;
	localparam int PD_W = 2 * COORD_BITS + 2;
	localparam int QW   = 1 + SQ + PD_W;

	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, start_z_q;
	logic signed [COORD_BITS-1:0] end_x_q, end_y_q, end_z_q;
	logic [SQ-1:0] length_sq_q, rad_sq_q;

	pic_pkg::reg_idx_t idx;
	logic wr_en;

	logic f_valid, f_ready, f_inr;
	logic [SQ-1:0] f_dot;
	logic [PD_W-1:0] f_pdsq;
	logic b_valid, b_ready;
	logic [QW-1:0] b_data;

	assign pready = 1'b1;
	assign idx    = pic_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= '0;
			start_y_q   <= '0;
			start_z_q   <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			end_z_q     <= '0;
			length_sq_q <= '0;
			rad_sq_q    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				pic_pkg::REG_AXIS_START_X: start_x_q   <= pwdata[COORD_BITS-1:0];
				pic_pkg::REG_AXIS_START_Y: start_y_q   <= pwdata[COORD_BITS-1:0];
				pic_pkg::REG_AXIS_START_Z: start_z_q   <= pwdata[COORD_BITS-1:0];
				pic_pkg::REG_AXIS_END_X:   end_x_q     <= pwdata[COORD_BITS-1:0];
				pic_pkg::REG_AXIS_END_Y:   end_y_q     <= pwdata[COORD_BITS-1:0];
				pic_pkg::REG_AXIS_END_Z:   end_z_q     <= pwdata[COORD_BITS-1:0];
				pic_pkg::REG_AXIS_LEN_SQ:  length_sq_q <= pwdata[SQ-1:0];
				pic_pkg::REG_RADIUS_SQ:    rad_sq_q    <= pwdata[SQ-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pic_pkg::REG_AXIS_START_X: prdata = pic_pkg::APB_DATA_W'(unsigned'(start_x_q));
			pic_pkg::REG_AXIS_START_Y: prdata = pic_pkg::APB_DATA_W'(unsigned'(start_y_q));
			pic_pkg::REG_AXIS_START_Z: prdata = pic_pkg::APB_DATA_W'(unsigned'(start_z_q));
			pic_pkg::REG_AXIS_END_X:   prdata = pic_pkg::APB_DATA_W'(unsigned'(end_x_q));
			pic_pkg::REG_AXIS_END_Y:   prdata = pic_pkg::APB_DATA_W'(unsigned'(end_y_q));
			pic_pkg::REG_AXIS_END_Z:   prdata = pic_pkg::APB_DATA_W'(unsigned'(end_z_q));
			pic_pkg::REG_AXIS_LEN_SQ:  prdata = pic_pkg::APB_DATA_W'(length_sq_q);
			pic_pkg::REG_RADIUS_SQ:    prdata = pic_pkg::APB_DATA_W'(rad_sq_q);
			default:                   prdata = '0;
		endcase
	end

	pic_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point),
		.start_x   (start_x_q),
		.start_y   (start_y_q),
		.start_z   (start_z_q),
		.end_x     (end_x_q),
		.end_y     (end_y_q),
		.end_z     (end_z_q),
		.length_sq (length_sq_q),
		.q_valid   (f_valid),
		.q_ready   (f_ready),
		.q_inr     (f_inr),
		.q_dot     (f_dot),
		.q_pdsq    (f_pdsq)
	);

	pic_fifo #(.W(QW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_inr, f_dot, f_pdsq}),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	pic_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_inr    (b_data[QW-1]),
		.in_dot    (b_data[QW-2:PD_W]),
		.in_pdsq   (b_data[PD_W-1:0]),
		.length_sq (length_sq_q),
		.rad_lim   (rad_sq_q),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_inside_within_radius: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.inside_res |-> result.axis_dist_sq <= rad_sq_q)
		else $error("inside result exceeds the squared radius");

	a_outside_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.inside_res |-> result.axis_dist_sq == '0)
		else $error("outside result carries a non-zero distance");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!f_ready |-> b_valid)
		else $error("queue reports full while empty");
`endif

endmodule

### rtl/core/pic_front.sv
`timescale 1ns / 1ps

module pic_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	pic_point_if.sink                             point,
	input  logic signed [COORD_BITS-1:0]          start_x,
	input  logic signed [COORD_BITS-1:0]          start_y,
	input  logic signed [COORD_BITS-1:0]          start_z,
	input  logic signed [COORD_BITS-1:0]          end_x,
	input  logic signed [COORD_BITS-1:0]          end_y,
	input  logic signed [COORD_BITS-1:0]          end_z,
	input  logic [pic_pkg::SQ_BITS-1:0]           length_sq,
	output logic                                  q_valid,
	input  logic                                  q_ready,
	output logic                                  q_inr,
	output logic [pic_pkg::SQ_BITS-1:0]           q_dot,
	output logic [2*COORD_BITS+1:0]               q_pdsq
);

	localparam int DW    = COORD_BITS + 1;
	localparam int PW    = 2 * DW;
	localparam int SQW   = 2 * COORD_BITS;
	localparam int PD_W  = 2 * COORD_BITS + 2;
	localparam int DOT_W = 2 * COORD_BITS + 3;
	localparam int CW    = (DOT_W > pic_pkg::SQ_BITS + 1) ? DOT_W : pic_pkg::SQ_BITS + 1;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] px_s1, py_s1, pz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0] mx_s2, my_s2, mz_s2;
	logic [SQW-1:0] sx_s2, sy_s2, sz_s2;
	logic inr_s3;
	logic [pic_pkg::SQ_BITS-1:0] dot_s3;
	logic [PD_W-1:0] pdsq_s3;

	logic signed [PW-1:0] sqx, sqy, sqz;
	logic signed [DOT_W-1:0] dot_sum;
	logic [CW-1:0] dot_ext;
	logic inr;

	assign adv         = !v_s3 || q_ready;
	assign point.ready = adv;

	assign sqx = px_s1 * px_s1;
	assign sqy = py_s1 * py_s1;
	assign sqz = pz_s1 * pz_s1;

	assign dot_sum = DOT_W'(mx_s2) + DOT_W'(my_s2) + DOT_W'(mz_s2);
	assign dot_ext = CW'(dot_sum);
	assign inr = !dot_sum[DOT_W-1] && (dot_ext <= CW'(length_sq))
		&& !((length_sq == '0) && (dot_sum == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= DW'(point.point_x) - DW'(start_x);
			py_s1   <= DW'(point.point_y) - DW'(start_y);
			pz_s1   <= DW'(point.point_z) - DW'(start_z);
			dx_s1   <= DW'(end_x) - DW'(start_x);
			dy_s1   <= DW'(end_y) - DW'(start_y);
			dz_s1   <= DW'(end_z) - DW'(start_z);
			mx_s2   <= px_s1 * dx_s1;
			my_s2   <= py_s1 * dy_s1;
			mz_s2   <= pz_s1 * dz_s1;
			sx_s2   <= sqx[SQW-1:0];
			sy_s2   <= sqy[SQW-1:0];
			sz_s2   <= sqz[SQW-1:0];
			inr_s3  <= inr;
			dot_s3  <= dot_ext[pic_pkg::SQ_BITS-1:0];
			pdsq_s3 <= PD_W'(sx_s2) + PD_W'(sy_s2) + PD_W'(sz_s2);
		end
	end

	assign q_valid = v_s3;
	assign q_inr   = inr_s3;
	assign q_dot   = dot_s3;
	assign q_pdsq  = pdsq_s3;

endmodule

### rtl/core/pic_fifo.sv
`timescale 1ns / 1ps

module pic_fifo #(
	parameter int W = 70
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] mem [pic_pkg::FIFO_DEPTH];
	logic [pic_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [pic_pkg::FIFO_PTR_W:0] count_q;
	logic push, pop;

	assign in_ready  = (count_q != (pic_pkg::FIFO_PTR_W+1)'(pic_pkg::FIFO_DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= in_data;
	end

endmodule

### rtl/core/pic_back.sv
`timescale 1ns / 1ps

module pic_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_inr,
	input  logic [pic_pkg::SQ_BITS-1:0] in_dot,
	input  logic [2*COORD_BITS+1:0]     in_pdsq,
	input  logic [pic_pkg::SQ_BITS-1:0] length_sq,
	input  logic [pic_pkg::SQ_BITS-1:0] rad_lim,
	pic_result_if.source                result
);

	localparam int SQ   = pic_pkg::SQ_BITS;
	localparam int HB   = pic_pkg::SQ_HALF;
	localparam int PD_W = 2 * COORD_BITS + 2;
	localparam int MW   = (PD_W > SQ + 1) ? PD_W : SQ + 1;

	logic adv;

	logic v_s1, inr_s1;
	logic [2*HB-1:0] aa_s1, ab_s1, bb_s1;
	logic [PD_W-1:0] pd_s1;

	logic [2*SQ-1:0] sq_full;

	logic            div_v_s   [SQ+1];
	logic            div_inr_s [SQ+1];
	logic [SQ-1:0]   div_rem_s [SQ+1];
	logic [SQ-1:0]   div_lo_s  [SQ+1];
	logic [SQ-1:0]   div_q_s   [SQ+1];
	logic [PD_W-1:0] div_pd_s  [SQ+1];

	logic res_v_q, res_in_q;
	logic [SQ-1:0] res_d_q;

	logic [MW-1:0] pdx, qx, dd;
	logic hit;

	assign adv      = !res_v_q || result.ready;
	assign in_ready = adv;

	assign sq_full = {aa_s1, {SQ{1'b0}}} + ((2*SQ)'(ab_s1) << (HB + 1)) + (2*SQ)'(bb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			div_v_s[0]   <= 1'b0;
		end else if (adv) begin
			v_s1         <= in_valid;
			div_v_s[0]   <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s1       <= in_inr;
			pd_s1        <= in_pdsq;
			aa_s1        <= in_dot[SQ-1:HB] * in_dot[SQ-1:HB];
			ab_s1        <= in_dot[SQ-1:HB] * in_dot[HB-1:0];
			bb_s1        <= in_dot[HB-1:0] * in_dot[HB-1:0];
			div_inr_s[0] <= inr_s1;
			div_pd_s[0]  <= pd_s1;
			div_rem_s[0] <= sq_full[2*SQ-1:SQ];
			div_lo_s[0]  <= sq_full[SQ-1:0];
			div_q_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_div
		logic [SQ:0] trial;
		logic        take;
		assign trial = {div_rem_s[k], div_lo_s[k][SQ-1]};
		assign take  = (trial >= {1'b0, length_sq});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v_s[k+1] <= 1'b0;
			else if (adv)
				div_v_s[k+1] <= div_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_inr_s[k+1] <= div_inr_s[k];
				div_pd_s[k+1]  <= div_pd_s[k];
				div_lo_s[k+1]  <= {div_lo_s[k][SQ-2:0], 1'b0};
				div_q_s[k+1]   <= {div_q_s[k][SQ-2:0], take};
				div_rem_s[k+1] <= take ? SQ'(trial - {1'b0, length_sq}) : trial[SQ-1:0];
			end
		end
	end

	assign pdx = MW'(div_pd_s[SQ]);
	assign qx  = MW'(div_q_s[SQ]);
	assign dd  = (qx > pdx) ? '0 : pdx - qx;
	assign hit = div_inr_s[SQ] && (dd <= MW'(rad_lim));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else if (adv)
			res_v_q <= div_v_s[SQ];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_in_q <= hit;
			res_d_q  <= hit ? dd[SQ-1:0] : '0;
		end
	end

	assign result.valid        = res_v_q;
	assign result.inside_res   = res_in_q;
	assign result.axis_dist_sq = res_d_q;

endmodule
